/* rtl/pngcsp_pkg.sv */
package pngcsp_pkg;

    localparam int unsigned DataW = 200;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;
    localparam logic [31:0] IHDR_LEN  = 32'd13;

    localparam logic [2:0] EV_IDAT   = 3'd0;
    localparam logic [2:0] EV_HEADER = 3'd1;
    localparam logic [2:0] EV_CHUNK  = 3'd2;
    localparam logic [2:0] EV_STREAM = 3'd3;
    localparam logic [2:0] EV_ERROR  = 3'd4;

    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_SIGNATURE   = 4'd1;
    localparam logic [3:0] ERR_IHDR_ORDER  = 4'd2;
    localparam logic [3:0] ERR_IHDR_LEN    = 4'd3;
    localparam logic [3:0] ERR_ZERO_SIZE   = 4'd4;
    localparam logic [3:0] ERR_IDAT_EARLY  = 4'd5;
    localparam logic [3:0] ERR_NO_IHDR     = 4'd6;
    localparam logic [3:0] ERR_NO_IDAT     = 4'd7;
    localparam logic [3:0] ERR_UNSUPPORTED = 4'd8;

    typedef enum logic [6:0] {
        PH_SIG   = 7'b000_0001,
        PH_LEN   = 7'b000_0010,
        PH_TYPE  = 7'b000_0100,
        PH_DATA  = 7'b000_1000,
        PH_CRC   = 7'b001_0000,
        PH_DONE  = 7'b010_0000,
        PH_ERROR = 7'b100_0000
    } t_phase;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  error_code;
        logic [2:0]  channels;
        logic [7:0]  interlace_kind;
        logic [7:0]  colour_kind;
        logic [7:0]  sample_depth;
        logic [31:0] pix_height;
        logic [31:0] pix_width;
        logic [31:0] chunk_check_word;
        logic [31:0] chunk_data_length;
        logic [31:0] chunk_type_code;
        logic [7:0]  payload_byte;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] chan_count(input logic [7:0] depth, input logic [7:0] colour,
                                              input logic [7:0] comp, input logic [7:0] filt,
                                              input logic [7:0] ilace);
        logic [2:0] c;
        c = 3'd0;
        if (depth == 8'd8 && comp == 8'd0 && filt == 8'd0 && ilace == 8'd0) begin
            if (colour == 8'd2) c = 3'd3;
            else if (colour == 8'd6) c = 3'd4;
        end
        return c;
    endfunction

endpackage

/* rtl/png_chunk_stream_parser_top.sv */
// PNG chunk stream parser.
// Input: one file byte per word on the slave stream (i_s_*), signature first.
// Output: at most one event word per input byte on the master stream (o_m_*);
//   tuser carries the event (IDAT byte, header, chunk done, stream done,
//   error), tdata the payload byte, chunk framing and header fields.
// An event is registered into the output word, or into the skid word while
//   the output word is still held, when the byte that causes it is taken.
//   Throughput: one byte per clock while o_s_tready is high.
// An output register plus one skid word decouple the two sides, so a byte
//   is still taken while one event waits; o_s_tready drops only while the
//   skid word is occupied and clears as soon as the receiver drains it.
// Reset (i_rst_n low, synchronous) returns to the signature check with all
//   chunk and header state cleared and both output words empty.
// After stream done or any error, bytes are taken and dropped with no
//   event until the next reset.
module png_chunk_stream_parser_top
    import pngcsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [7:0]       i_s_tdata,   // [7:0] data_byte
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [DataW-1:0] o_m_tdata,   // payload_byte, chunk_type_code,
                                          // chunk_data_length, chunk_check_word,
                                          // pix_width, pix_height,
                                          // sample_depth, colour_kind,
                                          // interlace_kind, channels,
                                          // error_code, zero pad
    output logic [2:0]       o_m_tuser    // [2:0] event_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [31:0] r_left, n_left;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_crc, n_crc;
    logic        r_any_done, n_any_done;
    logic        r_hdr_seen, n_hdr_seen;
    logic        r_idat_seen, n_idat_seen;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [7:0]  r_depth, n_depth;
    logic [7:0]  r_colour, n_colour;
    logic [7:0]  r_comp, n_comp;
    logic [7:0]  r_filt, n_filt;
    logic [7:0]  r_ilace, n_ilace;

    t_result     r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid;
    logic        res_valid;
    logic [2:0]  res_event;
    logic [3:0]  res_err;
    logic [7:0]  res_pay;
    logic        s_take, m_take;
    logic [3:0]  hdr_idx;
    logic        last_data;
    logic [7:0]  b;

    assign o_s_tready = !r_skid_valid;
    assign s_take     = i_s_tvalid && o_s_tready;
    assign m_take     = r_out_valid && i_m_tready;
    assign b          = i_s_tdata;
    assign hdr_idx    = 4'd13 - r_left[3:0];
    assign last_data  = (r_left == 32'd1);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_left      = r_left;
        n_len       = r_len;
        n_type      = r_type;
        n_crc       = r_crc;
        n_any_done  = r_any_done;
        n_hdr_seen  = r_hdr_seen;
        n_idat_seen = r_idat_seen;
        n_width     = r_width;
        n_height    = r_height;
        n_depth     = r_depth;
        n_colour    = r_colour;
        n_comp      = r_comp;
        n_filt      = r_filt;
        n_ilace     = r_ilace;
        res_valid   = 1'b0;
        res_event   = EV_IDAT;
        res_err     = ERR_NONE;
        res_pay     = 8'd0;

        unique case (r_phase)
            PH_SIG: begin
                if (b != sig_byte(r_pos)) begin
                    n_phase   = PH_ERROR;
                    res_valid = 1'b1;
                    res_event = EV_ERROR;
                    res_err   = ERR_SIGNATURE;
                end else if (r_pos == 3'd7) begin
                    n_pos   = 3'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], b};
                if (r_pos == 3'd3) begin
                    n_pos   = 3'd0;
                    n_phase = PH_TYPE;
                end else begin
                    n_pos = r_pos + 3'd1;
                end
            end
            PH_TYPE: begin
                n_type = {r_type[23:0], b};
                if (r_pos != 3'd3) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_pos = 3'd0;
                    priority if (n_type == TYPE_IHDR && r_any_done) begin
                        n_phase   = PH_ERROR;
                        res_valid = 1'b1;
                        res_event = EV_ERROR;
                        res_err   = ERR_IHDR_ORDER;
                    end else if (n_type == TYPE_IHDR && r_len != IHDR_LEN) begin
                        n_phase   = PH_ERROR;
                        res_valid = 1'b1;
                        res_event = EV_ERROR;
                        res_err   = ERR_IHDR_LEN;
                    end else if (n_type == TYPE_IDAT && !r_hdr_seen) begin
                        n_phase   = PH_ERROR;
                        res_valid = 1'b1;
                        res_event = EV_ERROR;
                        res_err   = ERR_IDAT_EARLY;
                    end else begin
                        if (n_type == TYPE_IHDR) begin
                            n_width  = 32'd0;
                            n_height = 32'd0;
                        end
                        if (n_type == TYPE_IDAT) n_idat_seen = 1'b1;
                        n_left  = r_len;
                        n_phase = (r_len == 32'd0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_left = r_left - 32'd1;
                if (last_data) n_phase = PH_CRC;
                if (r_type == TYPE_IDAT) begin
                    res_valid = 1'b1;
                    res_event = EV_IDAT;
                    res_pay   = b;
                end else if (r_type == TYPE_IHDR) begin
                    priority if (hdr_idx < 4'd4) n_width  = {r_width[23:0], b};
                    else if (hdr_idx < 4'd8)     n_height = {r_height[23:0], b};
                    else if (hdr_idx == 4'd8)    n_depth  = b;
                    else if (hdr_idx == 4'd9)    n_colour = b;
                    else if (hdr_idx == 4'd10)   n_comp   = b;
                    else if (hdr_idx == 4'd11)   n_filt   = b;
                    else                         n_ilace  = b;
                    if (last_data) begin
                        res_valid = 1'b1;
                        if (n_width == 32'd0 || n_height == 32'd0) begin
                            n_phase   = PH_ERROR;
                            res_event = EV_ERROR;
                            res_err   = ERR_ZERO_SIZE;
                        end else begin
                            n_hdr_seen = 1'b1;
                            res_event  = EV_HEADER;
                        end
                    end
                end
            end
            PH_CRC: begin
                n_crc = {r_crc[23:0], b};
                if (r_pos != 3'd3) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_pos      = 3'd0;
                    n_any_done = 1'b1;
                    res_valid  = 1'b1;
                    if (r_type == TYPE_IEND) begin
                        priority if (!r_hdr_seen) begin
                            n_phase   = PH_ERROR;
                            res_event = EV_ERROR;
                            res_err   = ERR_NO_IHDR;
                        end else if (!r_idat_seen) begin
                            n_phase   = PH_ERROR;
                            res_event = EV_ERROR;
                            res_err   = ERR_NO_IDAT;
                        end else if (chan_count(r_depth, r_colour, r_comp, r_filt,
                                                r_ilace) == 3'd0) begin
                            n_phase   = PH_ERROR;
                            res_event = EV_ERROR;
                            res_err   = ERR_UNSUPPORTED;
                        end else begin
                            n_phase   = PH_DONE;
                            res_event = EV_STREAM;
                        end
                    end else begin
                        n_phase   = PH_LEN;
                        res_event = EV_CHUNK;
                    end
                end
            end
            PH_DONE, PH_ERROR: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        res.event_res         = res_event;
        res.error_code        = res_err;
        res.channels          = chan_count(n_depth, n_colour, n_comp, n_filt, n_ilace);
        res.interlace_kind    = n_ilace;
        res.colour_kind       = n_colour;
        res.sample_depth      = n_depth;
        res.pix_height        = n_height;
        res.pix_width         = n_width;
        res.chunk_check_word  = n_crc;
        res.chunk_data_length = n_len;
        res.chunk_type_code   = n_type;
        res.payload_byte      = res_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SIG;
            r_pos       <= 3'd0;
            r_left      <= 32'd0;
            r_len       <= 32'd0;
            r_type      <= 32'd0;
            r_crc       <= 32'd0;
            r_any_done  <= 1'b0;
            r_hdr_seen  <= 1'b0;
            r_idat_seen <= 1'b0;
            r_width     <= 32'd0;
            r_height    <= 32'd0;
            r_depth     <= 8'd0;
            r_colour    <= 8'd0;
            r_comp      <= 8'd0;
            r_filt      <= 8'd0;
            r_ilace     <= 8'd0;
        end else if (s_take) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_left      <= n_left;
            r_len       <= n_len;
            r_type      <= n_type;
            r_crc       <= n_crc;
            r_any_done  <= n_any_done;
            r_hdr_seen  <= n_hdr_seen;
            r_idat_seen <= n_idat_seen;
            r_width     <= n_width;
            r_height    <= n_height;
            r_depth     <= n_depth;
            r_colour    <= n_colour;
            r_comp      <= n_comp;
            r_filt      <= n_filt;
            r_ilace     <= n_ilace;
        end
    end

    // output word plus one skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (s_take && res_valid) begin
            if (!r_out_valid || m_take) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= res;
            end
        end else if (m_take) begin
            r_out_valid  <= r_skid_valid;
            r_out        <= r_skid;
            r_skid_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.event_res;
    assign o_m_tdata  = {1'b0, r_out.error_code, r_out.channels, r_out.interlace_kind,
                         r_out.colour_kind, r_out.sample_depth, r_out.pix_height,
                         r_out.pix_width, r_out.chunk_check_word,
                         r_out.chunk_data_length, r_out.chunk_type_code,
                         r_out.payload_byte};

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output word");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("left error phase without reset");

    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |=> (r_phase == PH_DONE))
        else $error("left done phase without reset");

    a_err_code_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res != EV_ERROR) |->
            (r_out.error_code == ERR_NONE))
        else $error("error code set on a non-error event");

    a_payload_idat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_res != EV_IDAT) |-> (r_out.payload_byte == 8'd0))
        else $error("payload byte set on a non-IDAT event");

endmodule

/* tb/tb_png_chunk_stream_parser_top.sv */
module tb_png_chunk_stream_parser_top;
    import pngcsp_pkg::*;

    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
    localparam int unsigned PREFIX_ROWS = 24;
    // signature, IHDR length and type, widest width, smallest height;
    // no row produces an event on its own
    localparam logic [PREFIX_ROWS*8-1:0] PREFIX = {
        PNG_MAGIC, IHDR_LEN, TYPE_IHDR, 32'hFFFF_FFFF, 32'h0000_0001
    };
    localparam int unsigned LIVE_TARGET = 1100;

    typedef enum int {
        SC_CLEAN_END, SC_OPEN_END, SC_BAD_SIGNATURE, SC_BAD_IHDR_LEN, SC_ZERO_SIZE,
        SC_IDAT_EARLY, SC_NO_IHDR, SC_IHDR_LATE, SC_NO_IDAT, SC_UNSUPPORTED,
        SC_SECOND_IHDR
    } t_ending;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [DataW-1:0] o_m_tdata;
    logic [2:0]       o_m_tuser;

    png_chunk_stream_parser_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // framer model state
    t_phase      fr_phase;
    logic [2:0]  fr_pos;
    logic [31:0] fr_left;
    logic [31:0] fr_len;
    logic [31:0] fr_type;
    logic [31:0] fr_crc;
    bit          fr_any_done;
    bit          fr_hdr_ok;
    bit          fr_idat_seen;
    logic [31:0] fr_width;
    logic [31:0] fr_height;
    logic [7:0]  fr_depth;
    logic [7:0]  fr_colour;
    logic [7:0]  fr_comp;
    logic [7:0]  fr_filter;
    logic [7:0]  fr_ilace;

    t_result     pending_events[$];
    t_result     seen_event;
    t_result     due_event;
    int unsigned mismatch_count;
    int unsigned live_items;
    int unsigned sent_items;
    bit          quiet;
    t_ending     ending;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [2:0] colour_channels();
        logic [2:0] n;
        n = 3'd0;
        if (fr_depth == 8'd8 && fr_comp == 8'd0 && fr_filter == 8'd0 && fr_ilace == 8'd0) begin
            if (fr_colour == 8'd2) n = 3'd3;
            else if (fr_colour == 8'd6) n = 3'd4;
        end
        return n;
    endfunction

    function automatic t_result snapshot(input logic [2:0] ev, input logic [7:0] pay,
                                         input logic [3:0] err);
        t_result r;
        r.event_res         = ev;
        r.payload_byte      = pay;
        r.chunk_type_code   = fr_type;
        r.chunk_data_length = fr_len;
        r.chunk_check_word  = fr_crc;
        r.pix_width         = fr_width;
        r.pix_height        = fr_height;
        r.sample_depth      = fr_depth;
        r.colour_kind       = fr_colour;
        r.interlace_kind    = fr_ilace;
        r.channels          = colour_channels();
        r.error_code        = err;
        return r;
    endfunction

    task framer_reset();
        fr_phase     = PH_SIG;
        fr_pos       = '0;
        fr_left      = '0;
        fr_len       = '0;
        fr_type      = '0;
        fr_crc       = '0;
        fr_any_done  = 1'b0;
        fr_hdr_ok    = 1'b0;
        fr_idat_seen = 1'b0;
        fr_width     = '0;
        fr_height    = '0;
        fr_depth     = '0;
        fr_colour    = '0;
        fr_comp      = '0;
        fr_filter    = '0;
        fr_ilace     = '0;
    endtask

    task frame_byte(input logic [7:0] b, output bit has, output t_result r);
        logic [3:0] err;
        int         slot;
        has = 1'b0;
        r   = '0;
        err = ERR_NONE;
        case (fr_phase)
            PH_SIG: begin
                if (b != PNG_MAGIC[(7 - fr_pos) * 8 +: 8]) begin
                    err = ERR_SIGNATURE;
                end else if (fr_pos == 3'd7) begin
                    fr_pos   = '0;
                    fr_phase = PH_LEN;
                end else begin
                    fr_pos++;
                end
            end
            PH_LEN: begin
                fr_len = {fr_len[23:0], b};
                if (fr_pos == 3'd3) begin
                    fr_pos   = '0;
                    fr_phase = PH_TYPE;
                end else begin
                    fr_pos++;
                end
            end
            PH_TYPE: begin
                fr_type = {fr_type[23:0], b};
                if (fr_pos != 3'd3) begin
                    fr_pos++;
                end else begin
                    fr_pos = '0;
                    if (fr_type == TYPE_IHDR) begin
                        if (fr_any_done) begin
                            err = ERR_IHDR_ORDER;
                        end else if (fr_len != IHDR_LEN) begin
                            err = ERR_IHDR_LEN;
                        end else begin
                            fr_width  = '0;
                            fr_height = '0;
                        end
                    end else if (fr_type == TYPE_IDAT) begin
                        if (!fr_hdr_ok) err = ERR_IDAT_EARLY;
                        else fr_idat_seen = 1'b1;
                    end
                    if (err == ERR_NONE) begin
                        fr_left  = fr_len;
                        fr_phase = (fr_left == 0) ? PH_CRC : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                slot = 13 - int'(fr_left[3:0]);
                fr_left--;
                if (fr_left == 0) fr_phase = PH_CRC;
                if (fr_type == TYPE_IDAT) begin
                    has = 1'b1;
                    r   = snapshot(EV_IDAT, b, ERR_NONE);
                end else if (fr_type == TYPE_IHDR) begin
                    if (slot < 4) fr_width = {fr_width[23:0], b};
                    else if (slot < 8) fr_height = {fr_height[23:0], b};
                    else if (slot == 8) fr_depth = b;
                    else if (slot == 9) fr_colour = b;
                    else if (slot == 10) fr_comp = b;
                    else if (slot == 11) fr_filter = b;
                    else fr_ilace = b;
                    if (fr_left == 0) begin
                        if (fr_width == 0 || fr_height == 0) begin
                            err = ERR_ZERO_SIZE;
                        end else begin
                            fr_hdr_ok = 1'b1;
                            has       = 1'b1;
                            r         = snapshot(EV_HEADER, 8'h00, ERR_NONE);
                        end
                    end
                end
            end
            PH_CRC: begin
                fr_crc = {fr_crc[23:0], b};
                if (fr_pos != 3'd3) begin
                    fr_pos++;
                end else begin
                    fr_pos      = '0;
                    fr_any_done = 1'b1;
                    if (fr_type == TYPE_IEND) begin
                        if (!fr_hdr_ok) err = ERR_NO_IHDR;
                        else if (!fr_idat_seen) err = ERR_NO_IDAT;
                        else if (colour_channels() == 0) err = ERR_UNSUPPORTED;
                        else begin
                            fr_phase = PH_DONE;
                            has      = 1'b1;
                            r        = snapshot(EV_STREAM, 8'h00, ERR_NONE);
                        end
                    end else begin
                        fr_phase = PH_LEN;
                        has      = 1'b1;
                        r        = snapshot(EV_CHUNK, 8'h00, ERR_NONE);
                    end
                end
            end
            default: begin
            end
        endcase
        if (err != ERR_NONE) begin
            fr_phase = PH_ERROR;
            has      = 1'b1;
            r        = snapshot(EV_ERROR, 8'h00, err);
        end
    endtask

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
        mismatch_count++;
    endtask

    task compare_event(input t_result got, input t_result want);
        if (got.event_res != want.event_res)
            report_mismatch("event", 32'(got.event_res), 32'(want.event_res));
        if (got.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        if (got.chunk_type_code != want.chunk_type_code)
            report_mismatch("chunk_type_code", got.chunk_type_code, want.chunk_type_code);
        if (got.chunk_data_length != want.chunk_data_length)
            report_mismatch("chunk_data_length", got.chunk_data_length,
                            want.chunk_data_length);
        if (got.chunk_check_word != want.chunk_check_word)
            report_mismatch("chunk_check_word", got.chunk_check_word, want.chunk_check_word);
        if (got.pix_width != want.pix_width)
            report_mismatch("pix_width", got.pix_width, want.pix_width);
        if (got.pix_height != want.pix_height)
            report_mismatch("pix_height", got.pix_height, want.pix_height);
        if (got.sample_depth != want.sample_depth)
            report_mismatch("sample_depth", 32'(got.sample_depth), 32'(want.sample_depth));
        if (got.colour_kind != want.colour_kind)
            report_mismatch("colour_kind", 32'(got.colour_kind), 32'(want.colour_kind));
        if (got.interlace_kind != want.interlace_kind)
            report_mismatch("interlace_kind", 32'(got.interlace_kind),
                            32'(want.interlace_kind));
        if (got.channels != want.channels)
            report_mismatch("channels", 32'(got.channels), 32'(want.channels));
        if (got.error_code != want.error_code)
            report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_m_tvalid)) begin
                report_mismatch("o_m_tvalid unknown", 32'd0, 32'd0);
            end else if (o_m_tvalid && i_m_tready) begin
                seen_event = t_result'({o_m_tuser, o_m_tdata[198:0]});
                if (pending_events.size() == 0) begin
                    report_mismatch("unexpected event", 32'(seen_event.event_res), 32'd0);
                end else begin
                    due_event = pending_events.pop_front();
                    compare_event(seen_event, due_event);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_tready <= quiet || ($urandom_range(0, 99) >= 21);
    end

    task send_byte(input logic [7:0] b, input bit checked);
        bit      has;
        t_result r;
        while (!quiet && $urandom_range(0, 99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        sent_items++;
        if (fr_phase != PH_DONE && fr_phase != PH_ERROR) live_items++;
        frame_byte(b, has, r);
        if (checked && has) pending_events.push_back(r);
        @(negedge i_clk);
    endtask

    task send_word(input logic [31:0] w);
        int i;
        for (i = 3; i >= 0; i--) send_byte(w[i*8 +: 8], 1'b1);
    endtask

    function automatic logic [31:0] pick_crc();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'h0000_0000;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom_range(100, 300);
        if (r < 4) return 0;
        return $urandom_range(1, 24);
    endfunction

    function automatic logic [31:0] aux_type();
        logic [31:0] t;
        do t = $urandom; while (t == TYPE_IHDR || t == TYPE_IDAT || t == TYPE_IEND);
        return t;
    endfunction

    task send_chunk(input logic [31:0] ctype, input int unsigned nbytes);
        int unsigned i;
        send_word(nbytes);
        send_word(ctype);
        for (i = 0; i < nbytes; i++) send_byte(8'($urandom_range(0, 255)), 1'b1);
        send_word(pick_crc());
    endtask

    // hold the source off until every outstanding event has been drained
    task drain_pause();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending_events.size() != 0);
    endtask

    task walk_prefix(input int rows, input int patch_row, input logic [7:0] patch_val);
        int i;
        for (i = 0; i < rows; i++) begin
            if (i == patch_row) send_byte(patch_val, 1'b1);
            else send_byte(PREFIX[(PREFIX_ROWS - 1 - i) * 8 +: 8], 1'b0);
        end
    endtask

    // depth, colour, compression, filter, interlace and the CRC of IHDR
    task send_ihdr_tail(input bit broken);
        int unsigned k;
        logic [7:0]  c;
        k = broken ? $urandom_range(0, 4) : 5;
        send_byte((k == 0) ? (8'h08 ^ 8'($urandom_range(1, 255))) : 8'h08, 1'b1);
        if (k == 1) begin
            c = 8'($urandom_range(0, 255));
            if (c == 8'd2 || c == 8'd6) c = c + 8'd1;
        end else begin
            c = $urandom_range(0, 1) ? 8'd6 : 8'd2;
        end
        send_byte(c, 1'b1);
        send_byte((k == 2) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b1);
        send_byte((k == 3) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b1);
        send_byte((k == 4) ? 8'($urandom_range(1, 255)) : 8'h00, 1'b1);
        send_word(pick_crc());
    endtask

    task send_stream_body();
        bit first;
        first = 1'b1;
        while (live_items < LIVE_TARGET) begin
            if ($urandom_range(0, 15) == 0) drain_pause();
            quiet = (live_items >= 400 && live_items < 700);
            if (ending != SC_NO_IDAT && (first || $urandom_range(0, 9) < 6))
                send_chunk(TYPE_IDAT, pick_length());
            else
                send_chunk(aux_type(), pick_length());
            first = 1'b0;
        end
        quiet = 1'b0;
    endtask

    initial begin
        int unsigned pick;
        int unsigned n;
        int unsigned len;
        int          row;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = 8'h00;
        i_m_tready     = 1'b0;
        quiet          = 1'b0;
        mismatch_count = 0;
        live_items     = 0;
        sent_items     = 0;
        framer_reset();

        pick = $urandom_range(0, 19);
        case (pick)
            0:       ending = SC_BAD_SIGNATURE;
            1:       ending = SC_BAD_IHDR_LEN;
            2:       ending = SC_ZERO_SIZE;
            3:       ending = SC_IDAT_EARLY;
            4:       ending = SC_NO_IHDR;
            5:       ending = SC_IHDR_LATE;
            6:       ending = SC_NO_IDAT;
            7, 8:    ending = SC_UNSUPPORTED;
            9, 10:   ending = SC_SECOND_IHDR;
            11, 12:  ending = SC_OPEN_END;
            default: ending = SC_CLEAN_END;
        endcase

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        case (ending)
            SC_BAD_SIGNATURE: begin
                row = $urandom_range(0, 7);
                walk_prefix(PREFIX_ROWS, row, PREFIX[(PREFIX_ROWS - 1 - row) * 8 +: 8]
                                              ^ 8'($urandom_range(1, 255)));
            end
            SC_BAD_IHDR_LEN: begin
                walk_prefix(8, -1, 8'h00);
                len = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
                if (len == IHDR_LEN) len = len + 1;
                send_word(len);
                send_word(TYPE_IHDR);
            end
            SC_ZERO_SIZE: begin
                walk_prefix(PREFIX_ROWS, PREFIX_ROWS - 1, 8'h00);
                send_ihdr_tail(1'b0);
            end
            SC_IDAT_EARLY: begin
                walk_prefix(12, -1, 8'h00);
                send_word(TYPE_IDAT);
            end
            SC_NO_IHDR, SC_IHDR_LATE: begin
                walk_prefix(8, -1, 8'h00);
                n = $urandom_range(1, 3);
                repeat (n) send_chunk(aux_type(), pick_length());
                if (ending == SC_NO_IHDR) begin
                    send_chunk(TYPE_IEND, 0);
                end else begin
                    send_word(IHDR_LEN);
                    send_word(TYPE_IHDR);
                end
            end
            default: begin
                walk_prefix(PREFIX_ROWS, -1, 8'h00);
                send_ihdr_tail(ending == SC_UNSUPPORTED);
                drain_pause();
                send_stream_body();
                case (ending)
                    SC_CLEAN_END, SC_UNSUPPORTED, SC_NO_IDAT:
                        send_chunk(TYPE_IEND, $urandom_range(0, 3) == 0 ?
                                              $urandom_range(1, 8) : 0);
                    SC_SECOND_IHDR:
                        send_chunk(TYPE_IHDR, IHDR_LEN);
                    default: begin
                    end
                endcase
            end
        endcase

        // bytes after the stream has stopped must be swallowed silently
        if (ending != SC_OPEN_END) begin
            repeat (16) send_byte(8'($urandom_range(0, 255)), 1'b1);
            while (sent_items < LIVE_TARGET) send_byte(8'($urandom_range(0, 255)), 1'b1);
        end

        i_s_tvalid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
